// ===== design/aptb_pkg.sv =====
// ----------------------------------------------------------------------------
// aptb_pkg
// Shared constants and types for the alpha premultiply / trim bounds block.
// ----------------------------------------------------------------------------
package aptb_pkg;

    // Frame geometry
    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;

    // Pixel layout
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TRIM         = CFG_IDX_W'(3);

    // Effective frame settings seen by the bounds tracker
    typedef struct packed {
        logic [COORD_W-1:0] w_m1;
        logic [COORD_W-1:0] h_m1;
        logic               trim;
    } t_cfg;

    // Frame report attached to every result item
    typedef struct packed {
        logic               frame_done;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic               fully_transparent;
    } t_box;

endpackage

// ===== design/aptb_if.sv =====
// ----------------------------------------------------------------------------
// aptb interfaces
// Valid/ready channels for pixels in, results out and configuration writes.
// ----------------------------------------------------------------------------
interface aptb_pix_if;
    logic                       valid;
    logic                       ready;
    logic [aptb_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface aptb_res_if;
    logic                         valid;
    logic                         ready;
    logic [aptb_pkg::PIX_W-1:0]   pixel_out;
    logic                         frame_done;
    logic [aptb_pkg::COORD_W-1:0] box_min_x;
    logic [aptb_pkg::COORD_W-1:0] box_min_y;
    logic [aptb_pkg::COORD_W-1:0] box_max_x;
    logic [aptb_pkg::COORD_W-1:0] box_max_y;
    logic                         fully_transparent;

    modport source (output valid, output pixel_out, output frame_done,
                    output box_min_x, output box_min_y, output box_max_x,
                    output box_max_y, output fully_transparent, input ready);
    modport sink   (input valid, input pixel_out, input frame_done,
                    input box_min_x, input box_min_y, input box_max_x,
                    input box_max_y, input fully_transparent, output ready);
endinterface

interface aptb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aptb_pkg::CFG_IDX_W-1:0]  index;
    logic [aptb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/aptb_premul.sv =====
// ----------------------------------------------------------------------------
// aptb_premul
// Scales each colour channel by alpha/255 (floor), alpha passes unchanged.
// ----------------------------------------------------------------------------
module aptb_premul (
    input  logic [aptb_pkg::PIX_W-1:0] i_pixel,
    input  logic                       i_enable,
    output logic [aptb_pkg::PIX_W-1:0] o_pixel
);
    import aptb_pkg::*;

    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] scaled [3];

    assign alpha = i_pixel[PIX_W-1 -: CHAN_W];

    // Multiply, then divide by 255 exactly: (p + 1 + (p >> 8)) >> 8
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [2*CHAN_W-1:0] prod;
        logic [2*CHAN_W:0]   sum;

        assign prod = i_pixel[c*CHAN_W +: CHAN_W] * alpha;
        assign sum  = {1'b0, prod} + (2*CHAN_W+1)'(1)
                    + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]};
        assign scaled[c] = sum[2*CHAN_W-1:CHAN_W];
    end

    // Select scaled or raw colour
    always_comb begin
        if (i_enable) begin
            o_pixel = {alpha, scaled[2], scaled[1], scaled[0]};
        end else begin
            o_pixel = i_pixel;
        end
    end

endmodule

// ===== design/aptb_bounds.sv =====
// ----------------------------------------------------------------------------
// aptb_bounds
// Raster position counters and opaque bounding box, with the frame report.
// ----------------------------------------------------------------------------
module aptb_bounds (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_opaque,
    input  aptb_pkg::t_cfg              i_cfg,
    output aptb_pkg::t_box              o_box
);
    import aptb_pkg::*;

    localparam logic [COORD_W-1:0] EDGE_ONES = '1;

    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_left, n_left;
    logic [COORD_W-1:0] r_top, n_top;
    logic [COORD_W-1:0] r_right, n_right;
    logic [COORD_W-1:0] r_bottom, n_bottom;
    logic               r_seen, n_seen;

    logic row_end;
    logic frame_end;

    // Fold the current pixel into the box
    always_comb begin
        n_left   = r_left;
        n_top    = r_top;
        n_right  = r_right;
        n_bottom = r_bottom;
        n_seen   = r_seen;
        if (i_opaque) begin
            n_seen = 1'b1;
            if (!r_seen) begin
                n_left   = r_col;
                n_right  = r_col;
                n_top    = r_row;
                n_bottom = r_row;
            end else begin
                if (r_col < r_left)   n_left   = r_col;
                if (r_col > r_right)  n_right  = r_col;
                if (r_row < r_top)    n_top    = r_row;
                if (r_row > r_bottom) n_bottom = r_row;
            end
        end
    end

    assign row_end   = (r_col >= i_cfg.w_m1);
    assign frame_end = row_end && (r_row >= i_cfg.h_m1);

    // Advance the raster position
    always_comb begin
        n_col = r_col + COORD_W'(1);
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = r_row + COORD_W'(1);
        end
    end

    // Build the report for this pixel
    always_comb begin
        o_box = '0;
        if (frame_end) begin
            o_box.frame_done        = 1'b1;
            o_box.fully_transparent = i_cfg.trim && !n_seen;
            if (i_cfg.trim && n_seen) begin
                o_box.min_x = n_left;
                o_box.min_y = n_top;
                o_box.max_x = n_right;
                o_box.max_y = n_bottom;
            end else begin
                o_box.max_x = i_cfg.w_m1;
                o_box.max_y = i_cfg.h_m1;
            end
        end
    end

    // Update state when the item moves on; restart at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= EDGE_ONES;
            r_top    <= EDGE_ONES;
            r_right  <= '0;
            r_bottom <= '0;
            r_seen   <= 1'b0;
        end else if (i_advance) begin
            if (frame_end) begin
                r_col    <= '0;
                r_row    <= '0;
                r_left   <= EDGE_ONES;
                r_top    <= EDGE_ONES;
                r_right  <= '0;
                r_bottom <= '0;
                r_seen   <= 1'b0;
            end else begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_left   <= n_left;
                r_top    <= n_top;
                r_right  <= n_right;
                r_bottom <= n_bottom;
                r_seen   <= n_seen;
            end
        end
    end

endmodule

// ===== design/alpha_premultiply_trim_bounds_top.sv =====
// ----------------------------------------------------------------------------
// alpha_premultiply_trim_bounds_top
// RGBA premultiply with opaque bounding box over a raster-order frame.
// ----------------------------------------------------------------------------
// Takes one RGBA pixel per clock when not stalled (r in bits 7:0, alpha in
// bits 31:24) and returns one result per pixel: an input register holds
// the pixel, the premultiply and box update run in one pass, and a result
// register drives the output. Throughput is one pixel per clock when the
// output is not stalled. The result on the last pixel of a frame carries
// frame_done and the box of pixels with nonzero alpha (or the whole frame
// when trim is off or nothing was opaque). Width and height of 0 act as
// 1, above 4096 as 4096. Write configuration only while no pixel is in
// flight; the configuration channel is always ready.
module alpha_premultiply_trim_bounds_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aptb_pix_if.sink        i_pix,
    aptb_res_if.source      o_res,
    aptb_cfg_if.sink        i_cfg
);
    import aptb_pkg::*;

    // Configuration registers
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             r_premul;
    logic             r_trim;

    // Pipeline registers
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_s2_valid;
    logic [PIX_W-1:0] r_s2_pixel;
    t_box             r_s2_box;

    logic             s2_free;
    logic             s1_adv;
    logic [PIX_W-1:0] premul_pixel;
    t_box             box;
    t_cfg             eff_cfg;

    // Clamp a dimension to 1..MAX_DIM and return it minus one
    function automatic logic [COORD_W-1:0] dim_m1(input logic [DIM_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = COORD_W'(MAX_DIM - 1);
        end else begin
            res = COORD_W'(v - DIM_W'(1));
        end
        return res;
    endfunction

    // Accept configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_premul <= 1'b0;
            r_trim   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg.data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg.data;
                REG_PREMULTIPLY:  r_premul <= i_cfg.data[0];
                REG_TRIM:         r_trim   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign eff_cfg.w_m1 = dim_m1(r_width);
    assign eff_cfg.h_m1 = dim_m1(r_height);
    assign eff_cfg.trim = r_trim;

    // Handshake between stages
    assign s2_free     = !r_s2_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && s2_free;
    assign i_pix.ready = !r_s1_valid || s2_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_s1_pixel <= i_pix.pixel_in;
        end
    end

    aptb_premul u_premul (
        .i_pixel  (r_s1_pixel),
        .i_enable (r_premul),
        .o_pixel  (premul_pixel)
    );

    aptb_bounds u_bounds (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_adv),
        .i_opaque  (r_s1_pixel[PIX_W-1 -: CHAN_W] != '0),
        .i_cfg     (eff_cfg),
        .o_box     (box)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_pixel <= premul_pixel;
            r_s2_box   <= box;
        end
    end

    // Drive the result channel
    assign o_res.valid             = r_s2_valid;
    assign o_res.pixel_out         = r_s2_pixel;
    assign o_res.frame_done        = r_s2_box.frame_done;
    assign o_res.box_min_x         = r_s2_box.min_x;
    assign o_res.box_min_y         = r_s2_box.min_y;
    assign o_res.box_max_x         = r_s2_box.max_x;
    assign o_res.box_max_y         = r_s2_box.max_y;
    assign o_res.fully_transparent = r_s2_box.fully_transparent;

`ifndef SYNTHESIS
    a_box_only_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.frame_done |->
            o_res.box_min_x == '0 && o_res.box_min_y == '0 &&
            o_res.box_max_x == '0 && o_res.box_max_y == '0 && !o_res.fully_transparent)
        else $error("box fields set on a pixel that does not end the frame");

    a_transparent_whole_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.fully_transparent |->
            o_res.box_min_x == '0 && o_res.box_min_y == '0)
        else $error("transparent frame reported with a trimmed origin");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_done |->
            o_res.box_min_x <= o_res.box_max_x && o_res.box_min_y <= o_res.box_max_y)
        else $error("frame box has min beyond max");

    a_advance_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_s2_valid)
        else $error("item left the input register but no result is held");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready && r_s1_valid |-> s1_adv)
        else $error("input register overwritten while its item is stalled");
`endif

endmodule
